// ----- hw/rtl/mmh_pkg.sv -----
`timescale 1ns / 1ps

package mmh_pkg;

  // Hash constants
  localparam logic [31:0] C1      = 32'hcc9e2d51;
  localparam logic [31:0] C2      = 32'h1b873593;
  localparam logic [31:0] SEED    = 32'd42;
  localparam logic [31:0] H_ADD   = 32'he6546b64;
  localparam logic [31:0] F1      = 32'h85ebca6b;
  localparam logic [31:0] F2      = 32'hc2b2ae35;

  // Bytes in one full word
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  // One unit of work for the mixing engine
  typedef struct packed {
    logic [31:0] key;     // word or sign-extended tail byte
    logic [2:0]  nbytes;  // bytes this op adds to the length
    logic        mix;     // run k1 and h1 mix on key
    logic        fin;     // finish the message after this op
  } mmh_op_t;

  // Rotate left by a fixed amount
  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

endpackage

// ----- hw/rtl/murmur3_row_hash_stream.sv -----
`timescale 1ns / 1ps

// Streaming 32-bit Murmur3 hash (seed 42) of a byte message sent as
// little-endian 32-bit words; in_last marks the final word, whose
// in_valid_bytes (0 to 4, larger values count as 4) gives the bytes used.
// Tail bytes are sign-extended and mixed one at a time. A front end
// splits each request into mix ops and feeds a small queue; a single
// mixing engine drains it one op at a time (key mix, hash fold, and a
// finish at message end). New requests are taken while earlier ones are
// still mixed, except while the queue is full or a tail is being split.
// Results leave through a registered valid/ready port; the engine keeps
// working while a result waits, but a finish waits until the held result is taken.
module murmur3_row_hash_stream #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_data_word,
  input  logic [2:0]         in_valid_bytes,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_hash_value
);

  logic              push_valid;
  mmh_pkg::mmh_op_t  push_op;
  mmh_pkg::mmh_op_t  head_op;
  logic              q_full;
  logic              q_empty;
  logic              pop;

  mmh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .push_valid     (push_valid),
    .push_op        (push_op),
    .q_full         (q_full)
  );

  mmh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .pop        (pop),
    .head_op    (head_op),
    .q_full     (q_full),
    .q_empty    (q_empty)
  );

  mmh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_op        (head_op),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  // The front end never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(push_valid && q_full))
    else $error("push into full queue");

  // The engine never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && q_empty))
    else $error("pop from empty queue");

  // Every accepted request produces an op in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid && in_ready) |-> push_valid)
    else $error("accepted request not queued");

endmodule

// ----- hw/rtl/mmh_front.sv -----
`timescale 1ns / 1ps

module mmh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_data_word,
  input  logic [2:0]        in_valid_bytes,
  input  logic              in_last,
  output logic              push_valid,
  output mmh_pkg::mmh_op_t  push_op,
  input  logic              q_full
);

  logic        busy_r, busy_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  lidx_r, lidx_nxt;
  logic        take;
  logic        full_word;
  logic [7:0]  tail_byte;

  // Accept only when no tail is being split and the queue has room
  assign in_ready  = !busy_r && !q_full;
  assign take      = in_valid && in_ready;
  assign full_word = !in_last || (in_valid_bytes >= mmh_pkg::FULL_BYTES);

  always_comb begin
    busy_nxt   = busy_r;
    word_nxt   = word_r;
    idx_nxt    = idx_r;
    lidx_nxt   = lidx_r;
    push_valid = 1'b0;
    push_op    = '0;
    tail_byte  = word_r[8*idx_r +: 8];
    if (busy_r) begin
      // Emit the remaining tail bytes, one per cycle while the queue has room
      if (!q_full) begin
        push_valid     = 1'b1;
        push_op.key    = {{24{tail_byte[7]}}, tail_byte};
        push_op.nbytes = 3'd1;
        push_op.mix    = 1'b1;
        push_op.fin    = (idx_r == lidx_r);
        if (idx_r == lidx_r) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end else if (take) begin
      push_valid = 1'b1;
      if (full_word) begin
        push_op.key    = in_data_word;
        push_op.nbytes = mmh_pkg::FULL_BYTES;
        push_op.mix    = 1'b1;
        push_op.fin    = in_last;
      end else if (in_valid_bytes == 3'd0) begin
        // Empty tail: finish only
        push_op.fin = 1'b1;
      end else begin
        // First tail byte now, the rest later
        push_op.key    = {{24{in_data_word[7]}}, in_data_word[7:0]};
        push_op.nbytes = 3'd1;
        push_op.mix    = 1'b1;
        push_op.fin    = (in_valid_bytes == 3'd1);
        if (in_valid_bytes != 3'd1) begin
          busy_nxt = 1'b1;
          word_nxt = in_data_word;
          idx_nxt  = 2'd1;
          lidx_nxt = in_valid_bytes[1:0] - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    word_r <= word_nxt;
    idx_r  <= idx_nxt;
    lidx_r <= lidx_nxt;
  end

endmodule

// ----- hw/rtl/mmh_queue.sv -----
`timescale 1ns / 1ps

module mmh_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  mmh_pkg::mmh_op_t  push_op,
  input  logic              pop,
  output mmh_pkg::mmh_op_t  head_op,
  output logic              q_full,
  output logic              q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  mmh_pkg::mmh_op_t  mem_r [DEPTH];
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_full  = (cnt_r == DEPTH_C);
  assign q_empty = (cnt_r == '0);
  assign head_op = mem_r[rptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && !q_empty;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

endmodule

// ----- hw/rtl/mmh_back.sv -----
`timescale 1ns / 1ps

module mmh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mmh_pkg::mmh_op_t   head_op,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_hash_value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KA   = 3'd1;
  localparam logic [2:0] S_KB   = 3'd2;
  localparam logic [2:0] S_H    = 3'd3;
  localparam logic [2:0] S_FA   = 3'd4;
  localparam logic [2:0] S_FB   = 3'd5;
  localparam logic [2:0] S_FO   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  mmh_pkg::mmh_op_t   op_r, op_nxt;
  logic [31:0]        prod_r, prod_nxt;
  logic [31:0]        hash_r, hash_nxt;
  logic [31:0]        len_r, len_nxt;
  logic               oval_r, oval_nxt;
  logic signed [31:0] ohash_r, ohash_nxt;
  logic [31:0]        hx;
  logic [31:0]        fx;
  logic [31:0]        gx;
  logic               slot_free;

  assign out_valid      = oval_r;
  assign out_hash_value = ohash_r;
  assign slot_free      = !oval_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    prod_nxt  = prod_r;
    hash_nxt  = hash_r;
    len_nxt   = len_r;
    oval_nxt  = oval_r && !out_ready;
    ohash_nxt = ohash_r;
    pop       = 1'b0;
    hx        = mmh_pkg::rotl(hash_r ^ prod_r, 13);
    fx        = (hash_r ^ len_r) ^ ((hash_r ^ len_r) >> 16);
    gx        = prod_r ^ (prod_r >> 13);
    case (state_r)
      S_IDLE: begin
        // Take the next op from the queue
        if (!q_empty) begin
          pop       = 1'b1;
          op_nxt    = head_op;
          state_nxt = head_op.mix ? S_KA : S_FA;
        end
      end
      S_KA: begin
        prod_nxt  = op_r.key * mmh_pkg::C1;
        state_nxt = S_KB;
      end
      S_KB: begin
        prod_nxt  = mmh_pkg::rotl(prod_r, 15) * mmh_pkg::C2;
        state_nxt = S_H;
      end
      S_H: begin
        // Fold k1 into the running hash and count the bytes
        hash_nxt  = {hx[29:0], 2'b00} + hx + mmh_pkg::H_ADD;
        len_nxt   = len_r + {29'd0, op_r.nbytes};
        state_nxt = op_r.fin ? S_FA : S_IDLE;
      end
      S_FA: begin
        prod_nxt  = fx * mmh_pkg::F1;
        state_nxt = S_FB;
      end
      S_FB: begin
        prod_nxt  = gx * mmh_pkg::F2;
        state_nxt = S_FO;
      end
      S_FO: begin
        // Load the result register and restart the message
        if (slot_free) begin
          oval_nxt  = 1'b1;
          ohash_nxt = prod_r ^ (prod_r >> 16);
          hash_nxt  = mmh_pkg::SEED;
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hash_r  <= mmh_pkg::SEED;
      len_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      len_r   <= len_nxt;
      oval_r  <= oval_nxt;
    end
    op_r    <= op_nxt;
    prod_r  <= prod_nxt;
    ohash_r <= ohash_nxt;
  end

endmodule

// ----- bench/murmur3_row_hash_stream_tb.sv -----
`timescale 1ns / 1ps

module murmur3_row_hash_stream_tb;

  localparam int NUM_ITEMS   = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 33;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nvalid;
    logic        last;
    bit          hold;    // wait for all hashes before sending
    bit          steady;  // no idling on either side
  } word_req_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_data_word;
  logic [2:0]         in_valid_bytes;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_hash_value;

  word_req_t   word_queue[$];
  logic [31:0] hash_expected[$];
  logic [31:0] run_hash;
  logic [31:0] run_len;
  word_req_t   cur_req;
  bit          in_fire;
  bit          steady_mode;
  int          mismatches;
  int          cycles;

  murmur3_row_hash_stream i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_valid_bytes(in_valid_bytes),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hash_value(out_hash_value)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Scramble one key
  function automatic logic [31:0] murmur_key_mix(input logic [31:0] k);
    logic [31:0] t;
    t = k * mmh_pkg::C1;
    t = (t << 15) | (t >> 17);
    return t * mmh_pkg::C2;
  endfunction

  // Fold one scrambled key into the running hash
  function automatic logic [31:0] murmur_state_mix(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ k;
    t = (t << 13) | (t >> 19);
    return t * 32'd5 + mmh_pkg::H_ADD;
  endfunction

  // Avalanche the hash together with the message length
  function automatic logic [31:0] murmur_finalize(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] t;
    t = h ^ len;
    t = t ^ (t >> 16);
    t = t * mmh_pkg::F1;
    t = t ^ (t >> 13);
    t = t * mmh_pkg::F2;
    return t ^ (t >> 16);
  endfunction

  // Absorb one accepted request; push the hash when the message ends
  task automatic absorb_request(input logic [31:0] word, input logic [2:0] nvalid,
                                input logic last);
    int          n;
    logic [31:0] b;
    if (!last) begin
      run_hash = murmur_state_mix(run_hash, murmur_key_mix(word));
      run_len  = run_len + 32'd4;
    end else begin
      n = (nvalid > 3'd4) ? 4 : int'(nvalid);
      if (n == 4) begin
        run_hash = murmur_state_mix(run_hash, murmur_key_mix(word));
      end else begin
        for (int i = 0; i < n; i++) begin
          b = word >> (8 * i);
          b = {{24{b[7]}}, b[7:0]};
          run_hash = murmur_state_mix(run_hash, murmur_key_mix(b));
        end
      end
      run_len = run_len + n;
      hash_expected.push_back(murmur_finalize(run_hash, run_len));
      run_hash = mmh_pkg::SEED;
      run_len  = '0;
    end
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("t=%0t %s: got %08h want %08h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_word(input logic [31:0] word, input logic [2:0] nvalid, input logic last,
                          input bit hold);
    word_req_t r;
    r.word   = word;
    r.nvalid = nvalid;
    r.last   = last;
    r.hold   = hold;
    r.steady = (word_queue.size() >= 300) && (word_queue.size() < 450);
    word_queue.push_back(r);
  endtask

  // Driver: change inputs on the falling edge, hold a request until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (word_queue.size() > 0 && (!word_queue[0].hold || hash_expected.size() == 0) &&
            (steady_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = word_queue.pop_front();
          steady_mode = cur_req.steady;
          in_valid       <= 1'b1;
          in_data_word   <= cur_req.word;
          in_valid_bytes <= cur_req.nvalid;
          in_last        <= cur_req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: sample on the rising edge, predict and compare
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("murmur3_row_hash_stream: mismatch");
      $finish;
    end else begin
      in_fire <= rst_n && in_valid && in_ready;
      if (rst_n && in_valid && in_ready)
        absorb_request(in_data_word, in_valid_bytes, in_last);
      if (rst_n && out_valid && out_ready) begin
        if (hash_expected.size() == 0)
          log_mismatch("unexpected hash", out_hash_value, 32'h0);
        else if (out_hash_value !== hash_expected[0])
          log_mismatch("hash_value", out_hash_value, hash_expected.pop_front());
        else
          void'(hash_expected.pop_front());
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int nwords;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_word   = '0;
    in_valid_bytes = '0;
    in_last        = 1'b0;
    out_ready      = 1'b0;
    in_fire        = 1'b0;
    steady_mode    = 1'b0;
    mismatches     = 0;
    cycles         = 0;
    run_hash       = mmh_pkg::SEED;
    run_len        = '0;

    // Directed: empty message, every tail size, byte sign extension
    add_word(32'h0000_0000, 3'd0, 1'b1, 1'b0);
    add_word(32'h0000_0080, 3'd1, 1'b1, 1'b0);
    add_word(32'hffff_ffff, 3'd2, 1'b1, 1'b0);
    add_word(32'h7f80_ff01, 3'd3, 1'b1, 1'b0);
    add_word(32'h0000_0000, 3'd4, 1'b1, 1'b0);
    add_word(32'h1234_5678, 3'd5, 1'b1, 1'b0);
    add_word(32'hffff_ffff, 3'd6, 1'b1, 1'b0);
    add_word(32'h8080_8080, 3'd7, 1'b1, 1'b0);
    // Full words with junk byte counts, then an empty tail
    add_word(32'hffff_ffff, 3'd0, 1'b0, 1'b0);
    add_word(32'h0000_0000, 3'd7, 1'b0, 1'b0);
    add_word(32'h5a5a_5a5a, 3'd0, 1'b1, 1'b0);
    // Word then a three-byte negative tail
    add_word(32'ha5a5_a5a5, 3'd3, 1'b0, 1'b0);
    add_word(32'h8080_8080, 3'd3, 1'b1, 1'b0);
    // Back-to-back empties, then hold until drained
    add_word(32'hdead_beef, 3'd0, 1'b1, 1'b0);
    add_word(32'h0000_0000, 3'd0, 1'b1, 1'b0);
    add_word(32'h7fff_ffff, 3'd1, 1'b0, 1'b1);
    add_word(32'h7f7f_7f7f, 3'd3, 1'b1, 1'b0);

    // Random messages: mostly short, a few long
    while (word_queue.size() < NUM_ITEMS) begin
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      for (int i = 0; i < nwords; i++)
        add_word($urandom, 3'($urandom_range(0, 7)), 1'b0,
                 (i == 0) && ($urandom_range(0, 39) == 0));
      add_word($urandom, 3'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 7 : 4)), 1'b1,
               (nwords == 0) && ($urandom_range(0, 39) == 0));
    end

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain
    while (word_queue.size() > 0 || in_valid) @(posedge clk);
    while (hash_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("murmur3_row_hash_stream: match");
    else
      $display("murmur3_row_hash_stream: mismatch");
    $finish;
  end

endmodule
